// ----- hdl/esfp_pkg.sv -----
// ---------------------------------------------------------------------------
// esfp_pkg
// types, widths and constants shared by the four-way partition block
// ---------------------------------------------------------------------------
package esfp_pkg;

  localparam int MAX_STICKS = 20;
  localparam int NUM_SIDES  = 4;
  localparam int LEN_W      = 16;
  localparam int CNT_W      = $clog2(MAX_STICKS + 2);
  localparam int IDX_W      = $clog2(MAX_STICKS);
  localparam int SP_W       = $clog2(MAX_STICKS + 1);
  localparam int TOT_W      = LEN_W + $clog2(MAX_STICKS + 1);
  localparam int SIDE_W     = TOT_W - 2;
  localparam int MASK_W     = MAX_STICKS;
  localparam int VIS_DEPTH  = 1 << MAX_STICKS;

  typedef struct packed {
    logic [LEN_W-1:0] stick_length;
    logic             last;
  } in_t;

  typedef struct packed {
    logic can_form_square;
    logic overflow;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [TOT_W-1:0] total;
    logic             ovf;
  } desc_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [SIDE_W-1:0] open_sum;
    logic [CNT_W-1:0]  sides;
  } frame_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_ENTER,
    BK_CHECK,
    BK_SCAN,
    BK_DONE
  } back_state_e;

endpackage

// ----- hdl/esfp_ram.sv -----
// ---------------------------------------------------------------------------
// esfp_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
module esfp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- hdl/esfp_front.sv -----
// ---------------------------------------------------------------------------
// esfp_front
// accepts stick items, stores lengths and emits one set descriptor per set
// ---------------------------------------------------------------------------
module esfp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  esfp_pkg::in_t                 in_i,
  output logic                          push_o,
  output esfp_pkg::desc_t               desc_o,
  input  logic                          release_i,
  input  logic [esfp_pkg::IDX_W-1:0]    rd_idx_i,
  output logic [esfp_pkg::LEN_W-1:0]    rd_data_o
);

  logic [esfp_pkg::LEN_W-1:0] store_q [esfp_pkg::MAX_STICKS];
  logic [esfp_pkg::CNT_W-1:0] count_q, count_d;
  logic [esfp_pkg::TOT_W-1:0] total_q, total_d;
  logic                       busy_q, busy_d;
  logic                       accept;
  logic                       room;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign room       = count_q < esfp_pkg::CNT_W'(esfp_pkg::MAX_STICKS);
  assign rd_data_o  = store_q[rd_idx_i];

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    busy_d  = busy_q;
    push_o  = 1'b0;
    if (release_i) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      if (room) begin
        count_d = count_q + 1'b1;
        total_d = total_q + esfp_pkg::TOT_W'(in_i.stick_length);
      end else begin
        count_d = esfp_pkg::CNT_W'(esfp_pkg::MAX_STICKS + 1);
      end
    end
    desc_o.n     = count_d;
    desc_o.total = total_d;
    desc_o.ovf   = count_d > esfp_pkg::CNT_W'(esfp_pkg::MAX_STICKS);
    if (accept && in_i.last) begin
      push_o  = 1'b1;
      busy_d  = 1'b1;
      count_d = '0;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && room) begin
      store_q[count_q[esfp_pkg::IDX_W-1:0]] <= in_i.stick_length;
    end
  end

endmodule

// ----- hdl/esfp_queue.sv -----
// ---------------------------------------------------------------------------
// esfp_queue
// two-entry queue of set descriptors between front and back
// ---------------------------------------------------------------------------
module esfp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  esfp_pkg::desc_t desc_i,
  input  logic            pop_i,
  output logic            valid_o,
  output esfp_pkg::desc_t desc_o
);

  esfp_pkg::desc_t ent_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign desc_o  = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= desc_i;
    end
  end

endmodule

// ----- hdl/esfp_back.sv -----
// ---------------------------------------------------------------------------
// esfp_back
// clears the visited map and runs the depth-first bitmask search
// ---------------------------------------------------------------------------
module esfp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  esfp_pkg::desc_t               q_desc_i,
  output logic                          q_pop_o,
  output logic                          release_o,
  output logic [esfp_pkg::IDX_W-1:0]    rd_idx_o,
  input  logic [esfp_pkg::LEN_W-1:0]    rd_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output esfp_pkg::out_t                out_o
);

  localparam int MW = esfp_pkg::MASK_W;
  localparam int SW = esfp_pkg::SIDE_W;
  localparam int CW = esfp_pkg::CNT_W;

  esfp_pkg::back_state_e state_q, state_d;
  logic [MW-1:0] mask_q, mask_d, full_q, full_d, clr_q, clr_d;
  logic [SW-1:0] open_q, open_d, side_q, side_d;
  logic [CW-1:0] sides_q, sides_d, n_q, n_d, idx_q, idx_d;
  logic [esfp_pkg::SP_W-1:0] sp_q, sp_d, sp_m1;
  logic          found_q, found_d, ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  esfp_pkg::out_t out_q, out_d;
  esfp_pkg::frame_t stk_q [esfp_pkg::MAX_STICKS];
  esfp_pkg::frame_t top, frm;
  logic          push, do_pop;
  logic [MW-1:0] ram_addr;
  logic          ram_we, ram_wdata, ram_rdata;
  logic [SW:0]   s;
  logic [MW-1:0] bit_sel;

  esfp_ram #(.WIDTH(1), .DEPTH(esfp_pkg::VIS_DEPTH)) u_visited (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign rd_idx_o    = idx_q[esfp_pkg::IDX_W-1:0];
  assign s           = {1'b0, open_q} + (SW + 1)'(rd_data_i);
  assign bit_sel     = MW'(1) << idx_q;
  assign sp_m1       = sp_q - 1'b1;
  assign top         = stk_q[sp_m1[esfp_pkg::IDX_W-1:0]];
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign frm         = '{idx: idx_q[esfp_pkg::IDX_W-1:0], open_sum: open_q, sides: sides_q};

  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    full_d      = full_q;
    clr_d       = clr_q;
    open_d      = open_q;
    side_d      = side_q;
    sides_d     = sides_q;
    n_d         = n_q;
    idx_d       = idx_q;
    sp_d        = sp_q;
    found_d     = found_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    release_o   = 1'b0;
    ram_addr    = mask_q;
    ram_we      = 1'b0;
    ram_wdata   = 1'b0;
    push        = 1'b0;
    do_pop      = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      esfp_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          n_d     = q_desc_i.n;
          ovf_d   = q_desc_i.ovf;
          found_d = 1'b0;
          full_d  = ~({MW{1'b1}} << q_desc_i.n);
          side_d  = q_desc_i.total[esfp_pkg::TOT_W-1:2];
          clr_d   = '0;
          if (q_desc_i.ovf || q_desc_i.n < CW'(esfp_pkg::NUM_SIDES) ||
              q_desc_i.total[1:0] != 2'd0) begin
            state_d = esfp_pkg::BK_DONE;
          end else begin
            state_d = esfp_pkg::BK_CLEAR;
          end
        end
      end
      esfp_pkg::BK_CLEAR: begin
        ram_addr = clr_q;
        ram_we   = 1'b1;
        if (clr_q == full_q) begin
          mask_d  = '0;
          open_d  = '0;
          sides_d = '0;
          sp_d    = '0;
          state_d = esfp_pkg::BK_ENTER;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      esfp_pkg::BK_ENTER: begin
        if (mask_q == full_q) begin
          if (open_q == '0 && sides_q == CW'(esfp_pkg::NUM_SIDES)) begin
            found_d = 1'b1;
            state_d = esfp_pkg::BK_DONE;
          end else begin
            do_pop = 1'b1;
          end
        end else begin
          state_d = esfp_pkg::BK_CHECK;
        end
      end
      esfp_pkg::BK_CHECK: begin
        if (ram_rdata) begin
          do_pop = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = 1'b1;
          idx_d     = '0;
          state_d   = esfp_pkg::BK_SCAN;
        end
      end
      esfp_pkg::BK_SCAN: begin
        if (idx_q == n_q) begin
          do_pop = 1'b1;
        end else if ((mask_q & bit_sel) != '0 || s > {1'b0, side_q}) begin
          idx_d = idx_q + 1'b1;
        end else begin
          push   = 1'b1;
          sp_d   = sp_q + 1'b1;
          mask_d = mask_q | bit_sel;
          if (s == {1'b0, side_q}) begin
            open_d  = '0;
            sides_d = sides_q + 1'b1;
          end else begin
            open_d = s[SW-1:0];
          end
          state_d = esfp_pkg::BK_ENTER;
        end
      end
      esfp_pkg::BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_d.can_form_square = found_q && !ovf_q;
          out_d.overflow        = ovf_q;
          release_o             = 1'b1;
          state_d               = esfp_pkg::BK_IDLE;
        end
      end
      default: state_d = esfp_pkg::BK_IDLE;
    endcase
    if (do_pop) begin
      if (sp_q == '0) begin
        state_d = esfp_pkg::BK_DONE;
      end else begin
        sp_d    = sp_m1;
        mask_d  = mask_q & ~(MW'(1) << top.idx);
        open_d  = top.open_sum;
        sides_d = top.sides;
        idx_d   = CW'(top.idx) + 1'b1;
        state_d = esfp_pkg::BK_SCAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= esfp_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      sp_q        <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sp_q        <= sp_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    full_q  <= full_d;
    clr_q   <= clr_d;
    open_q  <= open_d;
    side_q  <= side_d;
    sides_q <= sides_d;
    n_q     <= n_d;
    idx_q   <= idx_d;
    ovf_q   <= ovf_d;
    out_q   <= out_d;
    if (push) begin
      stk_q[sp_q[esfp_pkg::IDX_W-1:0]] <= frm;
    end
  end

endmodule

// ----- hdl/equal_sum_four_way_partition.sv -----
// flow: sticks load at one per cycle unless in_stall_o is high, as it is from
// the last stick until the result is issued; unless the set is rejected early,
// 2^n visited entries (n sticks) are cleared before the search; out_o is registered
// throughput: one set at a time, the search loop over the visited ram sets the pace
// reset: asynchronous active low, clears the set counters, queue and search state
// ---------------------------------------------------------------------------
// equal_sum_four_way_partition
// decides whether a set of sticks splits into four groups of equal sum
// ---------------------------------------------------------------------------
module equal_sum_four_way_partition (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  esfp_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output esfp_pkg::out_t out_o
);

  logic                       push, q_valid, q_pop, rel;
  esfp_pkg::desc_t            desc_in, desc_out;
  logic [esfp_pkg::IDX_W-1:0] rd_idx;
  logic [esfp_pkg::LEN_W-1:0] rd_data;

  esfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .push_o     (push),
    .desc_o     (desc_in),
    .release_i  (rel),
    .rd_idx_i   (rd_idx),
    .rd_data_o  (rd_data)
  );

  esfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .desc_o  (desc_out)
  );

  esfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_desc_i    (desc_out),
    .q_pop_o     (q_pop),
    .release_o   (rel),
    .rd_idx_o    (rd_idx),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
